// ===== src/base64_decoder_assert.svh =====
// Assertion helpers for the base64 decoder
`ifndef BASE64_DECODER_ASSERT_SVH
`define BASE64_DECODER_ASSERT_SVH

// same-cycle implication
`define B64D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define B64D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/b64d_pkg.sv =====
package b64d_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_LENGTH  = 2'd1,
    ST_BAD_PADDING = 2'd2,
    ST_BAD_CHAR    = 2'd3
  } b64d_status_e;

  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [1:0] PadMax    = 2'd3;
  localparam logic [1:0] PadLimit  = 2'd2;
  localparam logic [1:0] GroupLast = 2'd3;
  localparam logic [1:0] BytesFull = 2'd3;

  // group request from the decode stage to the result buffer
  typedef struct packed {
    logic         valid;
    logic [1:0]   cnt;
    logic [23:0]  data;
    b64d_status_e status;
    logic         last;
  } b64d_grp_t;

  // bit 6 flags an illegal character
  function automatic logic [6:0] b64d_sextet(input logic [7:0] c);
    logic [6:0] v;
    v = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) v = {1'b0, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) v = {1'b0, 6'(c - 8'd71)};
    else if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 6'(c + 8'd4)};
    else if (c == CharPlus) v = 7'd62;
    else if (c == CharSlash) v = 7'd63;
    else if (c == CharPad) v = 7'd0;
    return v;
  endfunction

endpackage

// ===== src/b64d_core.sv =====
module b64d_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_in_i,
  input  logic               final_char_i,
  output b64d_pkg::b64d_grp_t grp_o,
  input  logic               grp_rdy_i
);
  import b64d_pkg::*;

  logic        valid_q;
  logic [7:0]  char_q;
  logic        fin_q;
  logic [17:0] accum_q, accum_d;
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  pad_q, pad_d;
  logic        bad_q, bad_d;

  logic [6:0]  sx;
  logic        group_end;
  logic [23:0] group;
  logic        fire;

  assign sx        = b64d_sextet(char_q);
  assign group_end = (pos_q == GroupLast);
  assign group     = {accum_q, sx[5:0]};

  always_comb begin
    bad_d = bad_q | sx[6];
    if (char_q == CharPad) begin
      pad_d = (pad_q == PadMax) ? PadMax : pad_q + 2'd1;
    end else begin
      pad_d = 2'd0;
    end
    grp_o.valid  = 1'b0;
    grp_o.cnt    = 2'd0;
    grp_o.data   = 24'd0;
    grp_o.status = ST_OK;
    grp_o.last   = 1'b0;
    if (!fin_q) begin
      if (group_end && !bad_d) begin
        grp_o.valid = valid_q;
        grp_o.cnt   = BytesFull;
        grp_o.data  = group;
      end
    end else begin
      grp_o.valid = valid_q;
      grp_o.cnt   = 2'd1;
      grp_o.last  = 1'b1;
      if (!group_end) begin
        grp_o.status = ST_BAD_LENGTH;
      end else if (pad_d > PadLimit) begin
        grp_o.status = ST_BAD_PADDING;
      end else if (bad_d) begin
        grp_o.status = ST_BAD_CHAR;
      end else begin
        grp_o.cnt  = BytesFull - pad_d;
        grp_o.data = group;
      end
    end
  end

  assign fire       = valid_q && (!grp_o.valid || grp_rdy_i);
  assign in_stall_o = valid_q && !fire;

  always_comb begin
    accum_d = group_end ? 18'd0 : {accum_q[11:0], sx[5:0]};
    pos_d   = pos_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= char_in_i;
      fin_q  <= final_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      pos_q   <= '0;
      pad_q   <= '0;
      bad_q   <= 1'b0;
    end else if (fire) begin
      if (fin_q) begin
        accum_q <= '0;
        pos_q   <= '0;
        pad_q   <= '0;
        bad_q   <= 1'b0;
      end else begin
        accum_q <= accum_d;
        pos_q   <= pos_d;
        pad_q   <= pad_d;
        bad_q   <= bad_d;
      end
    end
  end

endmodule

// ===== src/b64d_outbuf.sv =====
module b64d_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b64d_pkg::b64d_grp_t grp_i,
  output logic               grp_rdy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         byte_out_o,
  output logic [1:0]         status_o,
  output logic               run_end_o
);
  import b64d_pkg::*;

  logic [1:0]   cnt_q;
  logic [23:0]  data_q;
  b64d_status_e st_q;
  logic         last_q;
  logic         pop;
  logic         load;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign grp_rdy_o   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !out_stall_i);
  assign load        = grp_i.valid && grp_rdy_o;

  assign byte_out_o = data_q[23:16];
  assign status_o   = st_q;
  assign run_end_o  = last_q && (cnt_q == 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= grp_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= grp_i.data;
      st_q   <= grp_i.status;
      last_q <= grp_i.last;
    end else if (pop) begin
      data_q <= {data_q[15:0], 8'h00};
    end
  end

endmodule

// ===== src/base64_decoder.sv =====
// Streaming base64 decoder.
// Input channel: one character per request on char_in_i, with final_char_i
// set on the last character of a text. Output channel: one decoded byte per
// request on byte_out_o with status_o and run_end_o; run_end_o marks the last
// result of a text. A nonzero status comes as a single result with byte 0
// and run_end set; bytes already delivered for that text are to be dropped.
// Each result is registered in the input register, then in the result buffer.
// Throughput: one character per cycle while in_stall_o is low. Each fourth
// character loads up to three bytes into the result buffer, which drains one
// byte per cycle and takes the next group in the cycle its last byte leaves.
// A final character that ends a text off a group boundary, arriving while the
// buffer still holds two or three bytes, waits in the input register until
// the buffer's last byte leaves.
// When the receiver stalls, the buffer holds; a character that produces
// results waits in the input register and in_stall_o rises.
// Reset clears the group state and empties both registers; the first
// character after reset, or after a final character, starts a new text.
`include "base64_decoder_assert.svh"

module base64_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       final_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic [1:0] status_o,
  output logic       run_end_o
);
  import b64d_pkg::*;

  b64d_grp_t grp;
  logic      grp_rdy;

  b64d_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_in_i    (char_in_i),
    .final_char_i (final_char_i),
    .grp_o        (grp),
    .grp_rdy_i    (grp_rdy)
  );

  b64d_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp),
    .grp_rdy_o   (grp_rdy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .byte_out_o  (byte_out_o),
    .status_o    (status_o),
    .run_end_o   (run_end_o)
  );

  `B64D_ASSERT_IMP(a_err_single, out_valid_o && status_o != ST_OK, byte_out_o == 8'h00 && run_end_o, "error result must be a lone zero byte")
  `B64D_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o, "input stalled while result buffer empty")
  `B64D_ASSERT_NXT(a_grp_hold, grp.valid && !grp_rdy, grp.valid, "refused group request dropped")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import b64d_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } b64_char_t;

  typedef struct {
    logic [7:0]   data;
    b64d_status_e status;
    logic         last;
  } b64_byte_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_in_i    = 8'h00;
  logic       final_char_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [7:0] byte_out_o;
  logic [1:0] status_o;
  logic       run_end_o;

  b64_char_t char_q[$];
  b64_byte_t byte_q[$];
  b64_char_t nxt;
  b64_byte_t want;

  logic [17:0] sextets  = '0;
  logic [1:0]  grp_pos  = '0;
  logic [1:0]  pad_run  = '0;
  logic        bad_seen = 1'b0;

  logic in_take = 1'b0;
  logic steady  = 1'b0;
  int   in_gap  = 0;
  int   stall_left = 0;
  int   errors  = 0;

  base64_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_in_i   (char_in_i),
    .final_char_i(final_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .byte_out_o  (byte_out_o),
    .status_o    (status_o),
    .run_end_o   (run_end_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic fin);
    logic [5:0]  v;
    logic [23:0] grp;
    logic        grp_end;
    int          cnt;
    v       = '0;
    grp     = '0;
    grp_end = (grp_pos == GroupLast);
    if (c >= "A" && c <= "Z") v = 6'(c - "A");
    else if (c >= "a" && c <= "z") v = 6'(c - "a" + 26);
    else if (c >= "0" && c <= "9") v = 6'(c - "0" + 52);
    else if (c == CharPlus) v = 6'd62;
    else if (c == CharSlash) v = 6'd63;
    else if (c != CharPad) bad_seen = 1'b1;
    if (c == CharPad) begin
      if (pad_run < PadMax) pad_run = pad_run + 2'd1;
    end else begin
      pad_run = '0;
    end
    if (grp_end) grp = {sextets, v};
    else sextets = {sextets[11:0], v};

    if (!fin) begin
      if (grp_end && !bad_seen) begin
        byte_q.push_back('{grp[23:16], ST_OK, 1'b0});
        byte_q.push_back('{grp[15:8], ST_OK, 1'b0});
        byte_q.push_back('{grp[7:0], ST_OK, 1'b0});
      end
      if (grp_end) sextets = '0;
      grp_pos = grp_pos + 2'd1;
      return;
    end

    if (!grp_end) begin
      byte_q.push_back('{8'h00, ST_BAD_LENGTH, 1'b1});
    end else if (pad_run > PadLimit) begin
      byte_q.push_back('{8'h00, ST_BAD_PADDING, 1'b1});
    end else if (bad_seen) begin
      byte_q.push_back('{8'h00, ST_BAD_CHAR, 1'b1});
    end else begin
      cnt = 3 - int'(pad_run);
      for (int k = 0; k < cnt; k++)
        byte_q.push_back('{grp[23 - 8 * k -: 8], ST_OK, 1'(k == cnt - 1)});
    end
    sextets  = '0;
    grp_pos  = '0;
    pad_run  = '0;
    bad_seen = 1'b0;
  endfunction

  task automatic push_char(input logic [7:0] c, input logic fin);
    char_q.push_back('{c, fin});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // accept requests, predict, check results
  always @(posedge clk_i) begin
    in_take <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) decode_char(char_in_i, final_char_i);
      if (out_valid_o && !out_stall_i) begin
        if (byte_q.size() == 0) begin
          $display("%0t: unexpected result byte %02h status %0d run_end %0b", $time,
                   byte_out_o, status_o, run_end_o);
          errors++;
        end else begin
          want = byte_q.pop_front();
          if (byte_out_o !== want.data) begin
            $display("%0t: byte_out expected %02h actual %02h", $time, want.data,
                     byte_out_o);
            errors++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            errors++;
          end
          if (run_end_o !== want.last) begin
            $display("%0t: run_end expected %0b actual %0b", $time, want.last, run_end_o);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) steady <= !steady;
  end

  // drive requests, hold while stalled
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_take)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (char_q.size() > 0) begin
        nxt = char_q.pop_front();
        in_valid_i   <= 1'b1;
        char_in_i    <= nxt.ch;
        final_char_i <= nxt.fin;
        in_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap();
    end
  end

  initial begin
    #3_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int         kind;
    int         len;
    int         pads;
    int         idx;
    logic [7:0] ch;

    add_text("TWFuZQ==");
    add_text("+/9=");
    add_text("=A0z");
    add_text("AB");
    add_text("====");
    push_char(8'h00, 1'b0);
    push_char("A", 1'b0);
    push_char("B", 1'b0);
    push_char(8'hFF, 1'b1);

    while (char_q.size() < 124) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        len  = 4 * $urandom_range(1, 3);
        pads = $urandom_range(0, 2);
      end else begin
        len  = $urandom_range(1, 10);
        pads = $urandom_range(0, 4);
      end
      for (int i = 0; i < len; i++) begin
        idx = $urandom_range(0, 63);
        if (i >= len - pads) ch = CharPad;
        else if (idx < 26) ch = 8'("A" + idx);
        else if (idx < 52) ch = 8'("a" + idx - 26);
        else if (idx < 62) ch = 8'("0" + idx - 52);
        else if (idx == 62) ch = CharPlus;
        else ch = CharSlash;
        if (kind >= 6 && $urandom_range(0, 3) == 0) ch = 8'($urandom_range(0, 255));
        push_char(ch, i == len - 1);
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (char_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (byte_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== base64_decoder.f =====
+incdir+src
src/b64d_pkg.sv
src/b64d_core.sv
src/b64d_outbuf.sv
src/base64_decoder.sv
dv/tb.sv
